@@ hdl/prns_pkg.sv @@
// Shared constants, register codes and state encoding for the periodic
// radius neighbor search unit. No dependencies.
`default_nettype none

package prns_pkg;

	// Storage and field sizes
	localparam int SLOT_DEPTH = 64;
	localparam int COORD_W    = 24;
	localparam int SLOT_W     = 6;
	localparam int COUNT_W    = 7;
	localparam int RAD_W      = 23;
	localparam int HW_W       = 22;
	localparam int RANK_W     = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	// Derived datapath widths
	localparam int ADDR_W  = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
	localparam int POS_W   = 3 * COORD_W;
	localparam int DELTA_W = COORD_W + 1;
	localparam int WRAP_W  = ((DELTA_W > HW_W + 1) ? DELTA_W : HW_W + 1) + 1;
	localparam int SQ_IN_W = (COORD_W > RAD_W) ? COORD_W : RAD_W;
	localparam int SQ_W    = 2 * SQ_IN_W;
	localparam int ACC_W   = SQ_W + 2;

	// Distance sequencer steps: three deltas, wrap, square, accumulate
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_AX_X   = 3'd0;
	localparam logic [STEP_W-1:0] STEP_AX_Y   = 3'd1;
	localparam logic [STEP_W-1:0] STEP_AX_Z   = 3'd2;
	localparam logic [STEP_W-1:0] STEP_ACC_0  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_DONE   = 3'd5;

	// Reset value of the half world register
	localparam logic [HW_W-1:0] HALF_WORLD_RST = 22'h3FFFFF;

	// Item operation codes
	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOID_COUNT = 3'd0,
		CFG_SEP_RADIUS = 3'd1,
		CFG_ALI_RADIUS = 3'd2,
		CFG_COH_RADIUS = 3'd3,
		CFG_HALF_WORLD = 3'd4
	} cfg_reg_t;

	// Sequencer states, one-hot
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RDI  = 7'b0000010,
		S_REF  = 7'b0000100,
		S_RDJ  = 7'b0001000,
		S_AXIS = 7'b0010000,
		S_CMP  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

endpackage

`default_nettype wire

@@ hdl/prns_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module prns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/periodic_radius_neighbor_search_unit.sv @@
// Periodic fixed-radius neighbor search: position store, distance sequencer
// and result register. Depends on prns_pkg and prns_ram.
//
// Usage:
//  - Input channel (in_valid/in_stall): a load beat writes pos_x/y/z into
//    slot. A query beat searches the neighbors of slot;
//    in_stall stays high until the query's last result is in the output
//    register.
//  - Output channel (out_valid/out_stall): one beat per neighbor in
//    ascending slot order with its rank; the final beat has last set. A query
//    with no neighbor, or for a slot at or above boid_count, gives one beat
//    with found low.
//  - Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write
//    only while no query is running.
//  - Pace: a query walks every active slot, skipping its own. The single wrap
//    and square unit sets the pace, handling one axis per cycle over a six
//    step sequence, plus a RAM read and a compare per slot.
//  - A stalled output holds its beat; the search then waits whenever a new
//    neighbor must be pushed and the output register is still occupied.
//  - Reset clears the sequencer and loads register defaults; the position
//    store is not cleared and a slot must be loaded before it is searched.
`default_nettype none

module periodic_radius_neighbor_search_unit
	import prns_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         operation,
	input  wire logic [SLOT_W-1:0]            slot,
	input  wire logic signed [COORD_W-1:0]    pos_x,
	input  wire logic signed [COORD_W-1:0]    pos_y,
	input  wire logic signed [COORD_W-1:0]    pos_z,
	// output channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [SLOT_W-1:0]                 neighbor_slot,
	output logic                              found,
	output logic [RANK_W-1:0]                 rank,
	output logic                              last,
	// config channel
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

	// Config registers
	logic [COUNT_W-1:0] boid_count_q;
	logic [RAD_W-1:0]   sep_radius_q;
	logic [RAD_W-1:0]   ali_radius_q;
	logic [RAD_W-1:0]   coh_radius_q;
	logic [HW_W-1:0]    half_world_q;

	// Sequencer
	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic [COUNT_W-1:0] j_q;
	logic [SLOT_W-1:0]  slot_q;

	// Datapath
	logic [POS_W-1:0]          ram_rdata;
	logic [POS_W-1:0]          ref_q;
	logic [RAD_W-1:0]          rmax_q;
	logic [SQ_W-1:0]           rsq_q;
	logic signed [DELTA_W-1:0] d_q;
	logic [COORD_W-1:0]        mag_q;
	logic [SQ_W-1:0]           sq_q;
	logic [ACC_W-1:0]          acc_q;

	// Pending neighbor, held until it is known whether it is the last one
	logic                      pend_valid_q;
	logic [SLOT_W-1:0]         pend_slot_q;
	logic [RANK_W-1:0]         pend_rank_q;

	// Output register
	logic                      out_valid_q;
	logic [SLOT_W-1:0]         out_slot_q;
	logic                      out_found_q;
	logic [RANK_W-1:0]         out_rank_q;
	logic                      out_last_q;

	// Combinational signals
	logic                      in_accept;
	logic                      load_we;
	logic                      ram_re;
	logic [ADDR_W-1:0]         ram_raddr;
	logic [COUNT_W-1:0]        count_eff;
	logic                      slot_in_range;
	logic [RAD_W-1:0]          rmax_w;
	logic [COORD_W-1:0]        ax_ref;
	logic [COORD_W-1:0]        ax_oth;
	logic signed [DELTA_W-1:0] delta_w;
	logic [COORD_W-1:0]        mag_w;
	logic [SQ_IN_W-1:0]        sq_opnd;
	logic [SQ_W-1:0]           sq_w;
	logic                      hit;
	logic                      can_push;
	logic                      push_mid;
	logic                      push_fin;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Active slot count, clamped to the store depth
	assign count_eff = (boid_count_q > COUNT_W'(SLOT_DEPTH)) ? COUNT_W'(SLOT_DEPTH)
	                                                           : boid_count_q;
	assign slot_in_range = ({1'b0, slot} < count_eff);

	// Position store: {z, y, x} per slot
	assign load_we = in_accept && (operation == OP_LOAD)
	                 && ({1'b0, slot} < (SLOT_W + 1)'(SLOT_DEPTH));
	assign ram_re    = (state_q == S_RDI) || (state_q == S_RDJ);
	assign ram_raddr = (state_q == S_RDI) ? slot_q[ADDR_W-1:0] : j_q[ADDR_W-1:0];

	prns_ram #(
		.WIDTH (POS_W),
		.DEPTH (SLOT_DEPTH)
	) u_pos_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (slot[ADDR_W-1:0]),
		.wdata ({pos_z, pos_y, pos_x}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Largest of the three radii
	always_comb begin
		rmax_w = sep_radius_q;
		if (ali_radius_q > rmax_w) rmax_w = ali_radius_q;
		if (coh_radius_q > rmax_w) rmax_w = coh_radius_q;
	end

	// Select the axis for the delta stage
	always_comb begin
		case (step_q)
			STEP_AX_Y: begin
				ax_ref = ref_q[COORD_W +: COORD_W];
				ax_oth = ram_rdata[COORD_W +: COORD_W];
			end
			STEP_AX_Z: begin
				ax_ref = ref_q[2*COORD_W +: COORD_W];
				ax_oth = ram_rdata[2*COORD_W +: COORD_W];
			end
			default: begin
				ax_ref = ref_q[COORD_W-1:0];
				ax_oth = ram_rdata[COORD_W-1:0];
			end
		endcase
	end

	assign delta_w = DELTA_W'($signed(ax_oth)) - DELTA_W'($signed(ax_ref));

	// Minimum-image correction and magnitude of the registered delta
	always_comb begin
		logic signed [WRAP_W-1:0] dw;
		logic signed [WRAP_W-1:0] hw;
		logic signed [WRAP_W-1:0] res;
		logic signed [WRAP_W-1:0] absv;
		dw = WRAP_W'(d_q);
		hw = $signed(WRAP_W'(half_world_q));
		if (dw > hw) begin
			res = dw - (hw <<< 1);
		end else if (dw < -hw) begin
			res = dw + (hw <<< 1);
		end else begin
			res = dw;
		end
		absv  = res[WRAP_W-1] ? -res : res;
		mag_w = absv[COORD_W-1:0];
	end

	// Shared squarer: radius square once per query, then one axis per cycle
	assign sq_opnd = (state_q == S_REF) ? SQ_IN_W'(rmax_q) : SQ_IN_W'(mag_q);
	assign sq_w    = sq_opnd * sq_opnd;

	assign hit      = (acc_q < ACC_W'(rsq_q));
	assign can_push = !out_valid_q || !out_stall;
	assign push_mid = (state_q == S_CMP) && hit && pend_valid_q && can_push;
	assign push_fin = (state_q == S_FIN) && can_push;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boid_count_q <= '0;
			sep_radius_q <= '0;
			ali_radius_q <= '0;
			coh_radius_q <= '0;
			half_world_q <= HALF_WORLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BOID_COUNT: boid_count_q <= cfg_data[COUNT_W-1:0];
				CFG_SEP_RADIUS: sep_radius_q <= cfg_data[RAD_W-1:0];
				CFG_ALI_RADIUS: ali_radius_q <= cfg_data[RAD_W-1:0];
				CFG_COH_RADIUS: coh_radius_q <= cfg_data[RAD_W-1:0];
				CFG_HALF_WORLD: half_world_q <= cfg_data[HW_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= STEP_AX_X;
			j_q          <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept && (operation == OP_QUERY)) begin
						j_q          <= '0;
						pend_valid_q <= 1'b0;
						state_q      <= slot_in_range ? S_RDI : S_FIN;
					end
				end
				S_RDI: state_q <= S_REF;
				S_REF: state_q <= S_RDJ;
				S_RDJ: begin
					if (j_q >= count_eff) begin
						state_q <= S_FIN;
					end else if (j_q == {1'b0, slot_q}) begin
						j_q <= j_q + 1'b1;
					end else begin
						step_q  <= STEP_AX_X;
						state_q <= S_AXIS;
					end
				end
				S_AXIS: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_DONE) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (!hit || !pend_valid_q || can_push) begin
						if (hit) begin
							pend_valid_q <= 1'b1;
						end
						j_q     <= j_q + 1'b1;
						state_q <= S_RDJ;
					end
				end
				S_FIN: begin
					if (can_push) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			slot_q <= slot;
		end
		if (state_q == S_RDI) begin
			rmax_q <= rmax_w;
		end
		if (state_q == S_REF) begin
			ref_q <= ram_rdata;
			rsq_q <= sq_w;
		end
		// Advance the delta, wrap, square and accumulate pipeline
		if (state_q == S_AXIS) begin
			d_q   <= delta_w;
			mag_q <= mag_w;
			sq_q  <= sq_w;
			if (step_q == STEP_ACC_0) begin
				acc_q <= ACC_W'(sq_q);
			end else if (step_q > STEP_ACC_0) begin
				acc_q <= acc_q + ACC_W'(sq_q);
			end
		end
		// Replace the pending neighbor on a hit
		if ((state_q == S_CMP) && hit && (!pend_valid_q || can_push)) begin
			pend_slot_q <= j_q[SLOT_W-1:0];
			pend_rank_q <= pend_valid_q ? pend_rank_q + 1'b1 : '0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (push_mid) begin
			out_slot_q  <= pend_slot_q;
			out_found_q <= 1'b1;
			out_rank_q  <= pend_rank_q;
			out_last_q  <= 1'b0;
		end else if (push_fin) begin
			out_slot_q  <= pend_valid_q ? pend_slot_q : '0;
			out_found_q <= pend_valid_q;
			out_rank_q  <= pend_valid_q ? pend_rank_q : '0;
			out_last_q  <= 1'b1;
		end
	end

	// Output valid: set on push, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_mid || push_fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign neighbor_slot = out_slot_q;
	assign found         = out_found_q;
	assign rank          = out_rank_q;
	assign last          = out_last_q;

	// A push never overwrites a beat that the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(push_mid || push_fin))
		else $error("result pushed over a stalled beat");

	// A beat that is not the last one is taken only while its query runs
	a_mid_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !out_last_q) |-> (state_q != S_IDLE))
		else $error("non-final beat outside a running query");

	// The distance walk visits only active slots other than the queried one
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AXIS) |-> ((j_q < count_eff) && (j_q != {1'b0, slot_q})))
		else $error("distance walk on an inactive or self slot");

	// Neighbors are kept in ascending slot order
	a_pend_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_valid_q && ((state_q == S_RDJ) || (state_q == S_AXIS)
		                  || (state_q == S_CMP))) |-> ({1'b0, pend_slot_q} < j_q))
		else $error("pending neighbor not below walk index");

	// An empty answer is always the final beat
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> (out_last_q && (out_rank_q == '0)))
		else $error("empty answer not flagged last");

endmodule

`default_nettype wire

@@ sim/periodic_radius_neighbor_search_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for periodic_radius_neighbor_search_unit: directed table, then random
// load/query traffic under several register settings. Depends on prns_pkg and the unit's RTL.

module periodic_radius_neighbor_search_unit_tb;
	import prns_pkg::*;

	localparam int     HALF_PERIOD   = 4;
	localparam int     RESET_CYCLES  = 4;
	localparam int     SETTLE_CYCLES = 16;
	localparam int     TAIL_CYCLES   = 32;
	localparam int     BASE_ITEMS    = 10;
	localparam int     MAX_REPORTS   = 40;
	localparam longint RUN_LIMIT_NS  = 64'd40_000_000;

	// One output beat as the unit should present it
	typedef struct packed {
		logic [SLOT_W-1:0] nslot;
		logic              hit;
		logic [RANK_W-1:0] nrank;
		logic              is_last;
	} neighbor_beat_t;

	localparam neighbor_beat_t NO_NEIGHBOR = '{nslot: '0, hit: 1'b0, nrank: '0, is_last: 1'b1};

	// One row of the directed table: a register write or an input item
	typedef struct packed {
		bit                        is_reg;
		cfg_reg_t                  reg_idx;
		logic [CFG_DATA_W-1:0]     reg_val;
		op_t                       op;
		logic [SLOT_W-1:0]         s;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		bit                        typed;
		neighbor_beat_t            want;
	} stim_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         operation = OP_LOAD;
	logic [SLOT_W-1:0]            slot = '0;
	logic signed [COORD_W-1:0]    pos_x = '0;
	logic signed [COORD_W-1:0]    pos_y = '0;
	logic signed [COORD_W-1:0]    pos_z = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [SLOT_W-1:0]            neighbor_slot;
	logic                         found;
	logic [RANK_W-1:0]            rank;
	logic                         last;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [CFG_DATA_W-1:0]        cfg_data = '0;

	// Shadow of the unit's registers and position store
	logic [COUNT_W-1:0]           count_reg = '0;
	logic [RAD_W-1:0]             sep_reg = '0;
	logic [RAD_W-1:0]             ali_reg = '0;
	logic [RAD_W-1:0]             coh_reg = '0;
	logic [HW_W-1:0]              half_reg = HALF_WORLD_RST;
	logic signed [COORD_W-1:0]    boid_x [SLOT_DEPTH];
	logic signed [COORD_W-1:0]    boid_y [SLOT_DEPTH];
	logic signed [COORD_W-1:0]    boid_z [SLOT_DEPTH];
	bit   [SLOT_DEPTH-1:0]        loaded_slots = '0;

	neighbor_beat_t               pending_neighbors [$];

	int  gap_pct = 10;
	int  stall_pct = 62;
	bit  in_flight = 1'b0;
	int  mismatch_count = 0;
	int  n_loads = 0;
	int  n_queries = 0;
	int  n_reg_writes = 0;
	int  n_beats = 0;
	int  n_hits = 0;

	periodic_radius_neighbor_search_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.slot          (slot),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.neighbor_slot (neighbor_slot),
		.found         (found),
		.rank          (rank),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Stall the output at random, at the rate of the current idling mode
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t ns: error: %s", $time, msg);
		mismatch_count++;
	endtask

	// Squared per-axis distance after one minimum-image correction
	function automatic longint wrapped_sq(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		longint d;
		longint h;
		d = longint'(b) - longint'(a);
		h = longint'(half_reg);
		if (d > h)
			d = d - 2 * h;
		else if (d < -h)
			d = d + 2 * h;
		return d * d;
	endfunction

	// Queue the beats a query of slot s must produce, ascending slot order
	task automatic predict_neighbors(input logic [SLOT_W-1:0] s);
		int             eff;
		int             n;
		longint         r;
		longint         rsq;
		longint         dsq;
		neighbor_beat_t beat;
		eff = (count_reg > SLOT_DEPTH) ? SLOT_DEPTH : int'(count_reg);
		n = 0;
		if (int'(s) < eff) begin
			r = longint'(sep_reg);
			if (longint'(ali_reg) > r) r = longint'(ali_reg);
			if (longint'(coh_reg) > r) r = longint'(coh_reg);
			rsq = r * r;
			for (int j = 0; j < eff; j++) begin
				if (j != int'(s)) begin
					dsq = wrapped_sq(boid_x[s], boid_x[j]) + wrapped_sq(boid_y[s], boid_y[j])
						+ wrapped_sq(boid_z[s], boid_z[j]);
					if (dsq < rsq) begin
						beat.nslot = j[SLOT_W-1:0];
						beat.hit = 1'b1;
						beat.nrank = n[RANK_W-1:0];
						beat.is_last = 1'b0;
						pending_neighbors = {pending_neighbors, beat};
						n++;
					end
				end
			end
		end
		if (n == 0)
			pending_neighbors = {pending_neighbors, NO_NEIGHBOR};
		else
			pending_neighbors[pending_neighbors.size() - 1].is_last = 1'b1;
	endtask

	// Drop valid and wait until every queued beat has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_neighbors.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		in_flight = 1'b0;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		if (in_flight)
			drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(negedge clk);
			if (cfg_ready) break;
		end
		@(posedge clk);
		n_reg_writes++;
		case (idx)
			CFG_BOID_COUNT: count_reg = val[COUNT_W-1:0];
			CFG_SEP_RADIUS: sep_reg = val[RAD_W-1:0];
			CFG_ALI_RADIUS: ali_reg = val[RAD_W-1:0];
			CFG_COH_RADIUS: coh_reg = val[RAD_W-1:0];
			CFG_HALF_WORLD: half_reg = val[HW_W-1:0];
			default: ;
		endcase
	endtask

	// Send one input beat; record it at the edge that accepts it
	task automatic push_item(input op_t op, input logic [SLOT_W-1:0] s,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			input logic signed [COORD_W-1:0] z, input bit typed, input neighbor_beat_t want);
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		slot <= s;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		forever begin
			@(negedge clk);
			if (!in_stall) break;
		end
		@(posedge clk);
		in_flight = 1'b1;
		if (op == OP_LOAD) begin
			boid_x[s] = x;
			boid_y[s] = y;
			boid_z[s] = z;
			loaded_slots[s] = 1'b1;
			n_loads++;
		end else begin
			n_queries++;
			if (typed)
				pending_neighbors = {pending_neighbors, want};
			else
				predict_neighbors(s);
		end
	endtask

	function automatic stim_row_t reg_row(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic stim_row_t load_row(input logic [SLOT_W-1:0] s,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			input logic signed [COORD_W-1:0] z);
		stim_row_t r;
		r = '0;
		r.op = OP_LOAD;
		r.s = s;
		r.x = x;
		r.y = y;
		r.z = z;
		return r;
	endfunction

	function automatic stim_row_t query_row(input logic [SLOT_W-1:0] s);
		stim_row_t r;
		r = '0;
		r.op = OP_QUERY;
		r.s = s;
		return r;
	endfunction

	function automatic stim_row_t typed_query_row(input logic [SLOT_W-1:0] s,
			input neighbor_beat_t want);
		stim_row_t r;
		r = query_row(s);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	// Coordinate near the origin, hugging a world edge, or anywhere at all
	function automatic logic signed [COORD_W-1:0] pick_coord(input int unsigned span,
			input int unsigned hw);
		longint      v;
		int unsigned near;
		near = span / 8;
		case ($urandom_range(9))
			6, 7: v = longint'(hw) - longint'($urandom_range(near));
			8: v = longint'($urandom_range(near)) - longint'(hw);
			9: v = longint'($urandom);
			default: v = longint'($urandom_range(2 * span)) - longint'(span);
		endcase
		return v[COORD_W-1:0];
	endfunction

	// Check each accepted output beat against the oldest expectation
	always @(negedge clk) begin : check_beats
		neighbor_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_beats++;
			if (found) n_hits++;
			if (pending_neighbors.size() == 0) begin
				report_mismatch($sformatf("unexpected beat slot %0d found %0b rank %0d last %0b",
					neighbor_slot, found, rank, last));
			end else begin
				want = pending_neighbors.pop_front();
				if (neighbor_slot !== want.nslot)
					report_mismatch($sformatf("neighbor_slot got %0d want %0d",
						neighbor_slot, want.nslot));
				if (found !== want.hit)
					report_mismatch($sformatf("found got %0b want %0b", found, want.hit));
				if (rank !== want.nrank)
					report_mismatch($sformatf("rank got %0d want %0d", rank, want.nrank));
				if (last !== want.is_last)
					report_mismatch($sformatf("last got %0b want %0b", last, want.is_last));
			end
		end
	end

	initial begin
		stim_row_t             directed [$];
		int                    eff;
		int                    budget;
		int                    hole;
		op_t                   op;
		logic [SLOT_W-1:0]     s;
		logic [COUNT_W-1:0]    cnt;
		logic [CFG_DATA_W-1:0] sep;
		logic [CFG_DATA_W-1:0] ali;
		logic [CFG_DATA_W-1:0] coh;
		logic [HW_W-1:0]       hw;
		int unsigned           span;

		// Empty store, extremes, wrap across the world edge, zero and tiny half world
		directed = {directed, typed_query_row(6'd0, NO_NEIGHBOR)};
		directed = {directed, typed_query_row(6'd63, NO_NEIGHBOR)};
		directed = {directed, load_row(6'd0, 24'sd0, 24'sd0, 24'sd0)};
		directed = {directed, load_row(6'd1, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF)};
		directed = {directed, load_row(6'd2, 24'sh800000, 24'sh800000, 24'sh800000)};
		directed = {directed, load_row(6'd3, 24'sd256, 24'sd0, 24'sd0)};
		directed = {directed, load_row(6'd4, 24'sd0, -24'sd384, 24'sd128)};
		directed = {directed, load_row(6'd5, 24'sd4194000, 24'sd16, -24'sd16)};
		directed = {directed, load_row(6'd6, -24'sd4194000, -24'sd16, 24'sd16)};
		directed = {directed, load_row(6'd63, 24'sd1193046, -24'sd6636321, 24'sd986895)};
		directed = {directed, reg_row(CFG_BOID_COUNT, 23'd7)};
		directed = {directed, reg_row(CFG_SEP_RADIUS, 23'h000100)};
		directed = {directed, reg_row(CFG_ALI_RADIUS, 23'h000300)};
		directed = {directed, reg_row(CFG_COH_RADIUS, 23'h000200)};
		directed = {directed, reg_row(CFG_HALF_WORLD, 23'h3FFFFF)};
		directed = {directed, query_row(6'd0)};
		directed = {directed, query_row(6'd1)};
		directed = {directed, query_row(6'd2)};
		directed = {directed, query_row(6'd5)};
		directed = {directed, query_row(6'd6)};
		directed = {directed, typed_query_row(6'd7, NO_NEIGHBOR)};
		directed = {directed, typed_query_row(6'd63, NO_NEIGHBOR)};
		directed = {directed, reg_row(CFG_HALF_WORLD, 23'd0)};
		directed = {directed, query_row(6'd5)};
		directed = {directed, query_row(6'd0)};
		directed = {directed, reg_row(CFG_HALF_WORLD, 23'd1)};
		directed = {directed, reg_row(CFG_SEP_RADIUS, 23'h7FFFFF)};
		directed = {directed, reg_row(CFG_ALI_RADIUS, 23'd0)};
		directed = {directed, reg_row(CFG_COH_RADIUS, 23'd0)};
		directed = {directed, query_row(6'd0)};
		directed = {directed, query_row(6'd1)};
		directed = {directed, query_row(6'd2)};
		directed = {directed, query_row(6'd6)};
		directed = {directed, load_row(6'd0, -24'sd1, 24'sd1, -24'sd1)};
		directed = {directed, query_row(6'd3)};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed[k]) begin
			if (directed[k].is_reg)
				write_reg(directed[k].reg_idx, directed[k].reg_val);
			else
				push_item(directed[k].op, directed[k].s, directed[k].x, directed[k].y,
					directed[k].z, directed[k].typed, directed[k].want);
		end

		// Random phases, two register settings per idling mode
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					gap_pct = 10;
					stall_pct = 62;
				end
				1: begin
					gap_pct = 62;
					stall_pct = 10;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			case (ph)
				0: begin
					cnt = 7'd10;
					sep = CFG_DATA_W'($urandom_range(23'h000400));
					ali = 23'h000600;
					coh = CFG_DATA_W'($urandom_range(23'h000400));
					hw = 22'h000800;
					span = 32'h800;
				end
				1: begin
					// count beyond the store acts as a full store
					cnt = 7'd127;
					sep = 23'd0;
					ali = 23'd0;
					coh = 23'h7FFFFF;
					hw = 22'h3FFFFF;
					span = 32'h7FFFFF;
				end
				2: begin
					cnt = 7'd64;
					sep = 23'd0;
					ali = 23'd0;
					coh = 23'd0;
					hw = HW_W'($urandom_range(1, 22'h3FFFFF));
					span = 32'(hw);
				end
				3: begin
					cnt = 7'd24;
					sep = CFG_DATA_W'($urandom_range(23'h040000));
					ali = CFG_DATA_W'($urandom_range(23'h040000));
					coh = CFG_DATA_W'($urandom_range(23'h040000));
					hw = 22'd0;
					span = 32'h20000;
				end
				4: begin
					cnt = 7'd16;
					sep = CFG_DATA_W'($urandom_range(23'h7FFFFF));
					ali = CFG_DATA_W'($urandom_range(23'h7FFFFF));
					coh = CFG_DATA_W'($urandom_range(23'h7FFFFF));
					hw = 22'd1;
					span = 32'h7FFFFF;
				end
				default: begin
					cnt = COUNT_W'($urandom_range(2, 64));
					sep = CFG_DATA_W'($urandom_range(23'h002000));
					ali = CFG_DATA_W'($urandom_range(23'h002000));
					coh = CFG_DATA_W'($urandom_range(23'h002000));
					hw = HW_W'($urandom_range(22'h000400, 22'h004000));
					span = 32'(hw);
				end
			endcase
			write_reg(CFG_BOID_COUNT, CFG_DATA_W'(cnt));
			write_reg(CFG_SEP_RADIUS, sep);
			write_reg(CFG_ALI_RADIUS, ali);
			write_reg(CFG_COH_RADIUS, coh);
			write_reg(CFG_HALF_WORLD, CFG_DATA_W'(hw));
			eff = (cnt > SLOT_DEPTH) ? SLOT_DEPTH : int'(cnt);

			// Extend the phase by the slots that still need a first load
			budget = BASE_ITEMS;
			for (int k = 0; k < eff; k++)
				if (!loaded_slots[k]) budget++;

			repeat (budget) begin
				hole = -1;
				for (int k = eff - 1; k >= 0; k--)
					if (!loaded_slots[k]) hole = k;
				if ($urandom_range(99) < 30) begin
					op = OP_LOAD;
					s = SLOT_W'($urandom_range(SLOT_DEPTH - 1));
				end else begin
					op = OP_QUERY;
					if (eff == 0 || $urandom_range(9) == 0)
						s = SLOT_W'($urandom_range(SLOT_DEPTH - 1));
					else
						s = SLOT_W'($urandom_range(eff - 1));
					// never search a store with unloaded slots: fill the hole first
					if (int'(s) < eff && hole >= 0) begin
						op = OP_LOAD;
						s = hole[SLOT_W-1:0];
					end
				end
				push_item(op, s, pick_coord(span, 32'(hw)), pick_coord(span, 32'(hw)),
					pick_coord(span, 32'(hw)), 1'b0, NO_NEIGHBOR);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Summary: %0d loads and %0d queries sent, %0d register writes",
			n_loads, n_queries, n_reg_writes);
		$display("Summary: %0d result beats checked, %0d of them neighbors", n_beats, n_hits);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Hard stop if the unit hangs
	initial begin
		#(RUN_LIMIT_NS);
		$display("Timeout: %0d beats still pending", pending_neighbors.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
